FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The condition must never hold at a clock edge.
`define WRS_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

// The antecedent at an edge requires the consequent at the same edge.
`define WRS_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

// The antecedent at an edge requires the consequent at the next edge.
`define WRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define WRS_ASSERT_NEVER(lbl, cond)
`define WRS_ASSERT_IMPLIES(lbl, ante, cons)
`define WRS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: hdl/wrsched_pkg.sv
// ---------------------------------------------------------------------------
// Weekly relay schedule timer package
// Request and result types, command codes and shared constants.
// ---------------------------------------------------------------------------
package wrsched_pkg;

  // Default sizes of the relay bank and of each relay's timetable.
  localparam int DEF_RELAY_COUNT     = 8;
  localparam int DEF_SLOTS_PER_RELAY = 8;

  // Depth of the queues between the parts of the block.
  localparam int QUEUE_DEPTH = 2;

  // Field widths.
  localparam int TIME_W = 17;

  // Seconds per hour and per minute.
  localparam logic [TIME_W-1:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [TIME_W-1:0] SEC_PER_MIN  = 17'd60;

  // Action codes of an input request.
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_RELAY  = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Relay mode codes.
  localparam logic [3:0] MODE_TIMETABLE = 4'd0;
  localparam logic [3:0] MODE_ALWAYS    = 4'd1;
  localparam logic [3:0] MODE_HALF_HOUR = 4'd2;
  localparam logic [3:0] MODE_HOUR      = 4'd3;
  localparam logic [3:0] MODE_EVEN_HOUR = 4'd4;
  localparam logic [3:0] MODE_SIX_HOUR  = 4'd5;
  localparam logic [3:0] MODE_HALF_DAY  = 4'd6;
  localparam logic [3:0] MODE_TEN_SEC   = 4'd7;

  // Slot day selector meaning every day.
  localparam logic [2:0] DAY_EVERY = 3'd0;

  typedef struct packed {
    logic [1:0]        action;
    logic [2:0]        relay_index;
    logic [2:0]        slot_index;
    logic [2:0]        day;
    logic [TIME_W-1:0] on_seconds;
    logic [TIME_W-1:0] off_seconds;
    logic [3:0]        event_count;
    logic [3:0]        relay_mode;
    logic              manual;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
  } in_item_t;

  typedef struct packed {
    logic [2:0] out_relay;
    logic       relay_on;
    logic       last;
  } out_item_t;

  // Classified command passed from the front part to the back part.
  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_RELAY,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [2:0]        relay_index;
    logic [2:0]        slot_index;
    logic [2:0]        day;
    logic [TIME_W-1:0] on_seconds;
    logic [TIME_W-1:0] off_seconds;
    logic [3:0]        event_count;
    logic [3:0]        relay_mode;
    logic              manual;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic [TIME_W-1:0] now_seconds;
  } cmd_t;

  // One stored timetable slot.
  typedef struct packed {
    logic [2:0]        day;
    logic [TIME_W-1:0] on_seconds;
    logic [TIME_W-1:0] off_seconds;
  } slot_entry_t;

endpackage

FILE: hdl/wrsched_fifo.sv
// ---------------------------------------------------------------------------
// Weekly relay schedule timer queue
// Small first-in first-out buffer with full and empty flags.
// ---------------------------------------------------------------------------
module wrsched_fifo #(
  parameter type data_t = logic,
  parameter int  DEPTH  = wrsched_pkg::QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  data_t wr_data,
  output logic  full,
  input  logic  pop,
  output data_t rd_data,
  output logic  empty
);
  import wrsched_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  data_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign rd_data = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: hdl/wrsched_front.sv
// ---------------------------------------------------------------------------
// Weekly relay schedule timer front end
// Accepts requests, drops ignored ones and classifies the rest into commands.
// ---------------------------------------------------------------------------
module wrsched_front #(
  parameter int RELAY_COUNT     = wrsched_pkg::DEF_RELAY_COUNT,
  parameter int SLOTS_PER_RELAY = wrsched_pkg::DEF_SLOTS_PER_RELAY
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  wrsched_pkg::in_item_t in_data,
  output logic                 q_push,
  input  logic                 q_full,
  output wrsched_pkg::cmd_t    q_data
);
  import wrsched_pkg::*;

  logic valid_r, valid_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic take;
  logic keep;
  logic relay_ok, slot_ok;

  // The stage takes a new request when it is empty or drains this cycle.
  assign full   = valid_r && q_full;
  assign take   = push && !full;
  assign q_push = valid_r && !q_full;
  assign q_data = cmd_r;

  assign relay_ok = (int'(in_data.relay_index) < RELAY_COUNT);
  assign slot_ok  = (int'(in_data.slot_index) < SLOTS_PER_RELAY);

  // Classify the request and precompute the time of day for ticks.
  always_comb begin
    keep                = 1'b0;
    cmd_nxt.kind        = CMD_TICK;
    cmd_nxt.relay_index = in_data.relay_index;
    cmd_nxt.slot_index  = in_data.slot_index;
    cmd_nxt.day         = in_data.day;
    cmd_nxt.on_seconds  = in_data.on_seconds;
    cmd_nxt.off_seconds = in_data.off_seconds;
    cmd_nxt.event_count = in_data.event_count;
    cmd_nxt.relay_mode  = in_data.relay_mode;
    cmd_nxt.manual      = in_data.manual;
    cmd_nxt.hour        = in_data.hour;
    cmd_nxt.minute      = in_data.minute;
    cmd_nxt.second      = in_data.second;
    cmd_nxt.now_seconds = TIME_W'(in_data.hour) * SEC_PER_HOUR
                        + TIME_W'(in_data.minute) * SEC_PER_MIN
                        + TIME_W'(in_data.second);
    unique case (in_data.action)
      ACT_LOAD: begin
        cmd_nxt.kind = CMD_LOAD;
        keep         = relay_ok && slot_ok;
      end
      ACT_RELAY: begin
        cmd_nxt.kind = CMD_RELAY;
        keep         = relay_ok;
      end
      ACT_TICK: begin
        cmd_nxt.kind = CMD_TICK;
        keep         = 1'b1;
      end
      ACT_UNUSED: begin
        keep = 1'b0;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (take) begin
      valid_nxt = keep;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Command payload register.
  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

FILE: hdl/wrsched_back.sv
// ---------------------------------------------------------------------------
// Weekly relay schedule timer back end
// Executes commands: stores slots and relay settings, and on a tick walks
// the relays and their timetables to produce one result per automatic relay.
// ---------------------------------------------------------------------------
module wrsched_back #(
  parameter int RELAY_COUNT     = wrsched_pkg::DEF_RELAY_COUNT,
  parameter int SLOTS_PER_RELAY = wrsched_pkg::DEF_SLOTS_PER_RELAY
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  output logic                   q_pop,
  input  wrsched_pkg::cmd_t      q_data,
  input  logic                   r_full,
  output logic                   r_push,
  output wrsched_pkg::out_item_t r_data
);
  import wrsched_pkg::*;

  localparam int RW    = (RELAY_COUNT > 1) ? $clog2(RELAY_COUNT) : 1;
  localparam int CW    = $clog2(SLOTS_PER_RELAY + 1);
  localparam int DEPTH = RELAY_COUNT * SLOTS_PER_RELAY;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [RW-1:0] LAST_RELAY = RW'(RELAY_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RELAY,
    S_WALK,
    S_EMIT
  } state_t;

  // Wave pattern level for a fixed mode.
  function automatic logic wave_level(input logic [3:0] mode, input logic [4:0] hr,
                                      input logic [5:0] mn, input logic [5:0] sc);
    logic [5:0] m30;
    logic [5:0] m60;
    logic [4:0] h24;
    logic [4:0] h12;
    logic [5:0] s20;
    logic       lvl;
    m60 = (mn >= 6'd60) ? mn - 6'd60 : mn;
    m30 = (m60 >= 6'd30) ? m60 - 6'd30 : m60;
    h24 = (hr >= 5'd24) ? hr - 5'd24 : hr;
    h12 = (h24 >= 5'd12) ? h24 - 5'd12 : h24;
    if (sc >= 6'd60) begin
      s20 = sc - 6'd60;
    end else if (sc >= 6'd40) begin
      s20 = sc - 6'd40;
    end else if (sc >= 6'd20) begin
      s20 = sc - 6'd20;
    end else begin
      s20 = sc;
    end
    unique case (mode)
      MODE_ALWAYS:    lvl = 1'b1;
      MODE_HALF_HOUR: lvl = (m30 < 6'd15);
      MODE_HOUR:      lvl = (m60 < 6'd30);
      MODE_EVEN_HOUR: lvl = !hr[0];
      MODE_SIX_HOUR:  lvl = (h12 < 5'd6);
      MODE_HALF_DAY:  lvl = (h24 < 5'd12);
      MODE_TEN_SEC:   lvl = (s20 < 6'd10);
      default:        lvl = 1'b0;
    endcase
    return lvl;
  endfunction

  // True when a stored slot covers the given weekday and time of day.
  function automatic logic slot_hit(input slot_entry_t e, input logic [3:0] want,
                                    input logic [TIME_W-1:0] now);
    logic day_ok;
    logic win_ok;
    day_ok = (e.day == DAY_EVERY) || ({1'b0, e.day} == want);
    if (e.on_seconds < e.off_seconds) begin
      win_ok = (now >= e.on_seconds) && (now < e.off_seconds);
    end else if (e.on_seconds > e.off_seconds) begin
      win_ok = (now >= e.on_seconds) || (now < e.off_seconds);
    end else begin
      win_ok = 1'b1;
    end
    return day_ok && win_ok;
  endfunction

  state_t            state_r, state_nxt;
  logic [RW-1:0]     relay_r, relay_nxt;
  logic [CW-1:0]     slot_r, slot_nxt;
  logic [CW-1:0]     limit_r, limit_nxt;
  logic              pend_r, pend_nxt;
  logic              level_r, level_nxt;
  logic [3:0]        want_r, want_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [4:0]        hour_r, hour_nxt;
  logic [5:0]        minute_r, minute_nxt;
  logic [5:0]        second_r, second_nxt;
  logic [3:0]        count_r  [RELAY_COUNT];
  logic [3:0]        count_nxt[RELAY_COUNT];
  logic [3:0]        mode_r   [RELAY_COUNT];
  logic [3:0]        mode_nxt [RELAY_COUNT];
  logic              manual_r [RELAY_COUNT];
  logic              manual_nxt[RELAY_COUNT];

  slot_entry_t       mem [DEPTH];
  slot_entry_t       mem_q;
  slot_entry_t       wr_entry;
  logic              mem_we;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [RW-1:0]     cmd_relay;
  logic              later_live;

  assign cmd_relay           = RW'(q_data.relay_index);
  assign wr_addr             = AW'(int'(cmd_relay) * SLOTS_PER_RELAY
                                   + int'(q_data.slot_index));
  assign rd_addr             = AW'(int'(relay_r) * SLOTS_PER_RELAY + int'(slot_r));
  assign wr_entry.day        = q_data.day;
  assign wr_entry.on_seconds = q_data.on_seconds;
  assign wr_entry.off_seconds = q_data.off_seconds;

  // A result is the last of its tick when no later relay is automatic.
  always_comb begin
    later_live = 1'b0;
    for (int k = 0; k < RELAY_COUNT; k++) begin
      if ((RW'(k) > relay_r) && !manual_r[k]) begin
        later_live = 1'b1;
      end
    end
  end

  assign r_data.out_relay = 3'(relay_r);
  assign r_data.relay_on  = level_r;
  assign r_data.last      = !later_live;

  // Command sequencer.
  always_comb begin
    state_nxt  = state_r;
    relay_nxt  = relay_r;
    slot_nxt   = slot_r;
    limit_nxt  = limit_r;
    pend_nxt   = pend_r;
    level_nxt  = level_r;
    want_nxt   = want_r;
    now_nxt    = now_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    count_nxt  = count_r;
    mode_nxt   = mode_r;
    manual_nxt = manual_r;
    q_pop      = 1'b0;
    r_push     = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_data.kind)
            CMD_LOAD: begin
              mem_we = 1'b1;
            end
            CMD_RELAY: begin
              count_nxt[cmd_relay]  = q_data.event_count;
              mode_nxt[cmd_relay]   = q_data.relay_mode;
              manual_nxt[cmd_relay] = q_data.manual;
            end
            CMD_TICK: begin
              want_nxt   = {1'b0, q_data.day} + 4'd1;
              now_nxt    = q_data.now_seconds;
              hour_nxt   = q_data.hour;
              minute_nxt = q_data.minute;
              second_nxt = q_data.second;
              relay_nxt  = '0;
              state_nxt  = S_RELAY;
            end
            default: begin
            end
          endcase
        end
      end
      S_RELAY: begin
        // Skip manual relays; wave relays resolve at once.
        if (manual_r[relay_r]) begin
          if (relay_r == LAST_RELAY) begin
            state_nxt = S_IDLE;
          end else begin
            relay_nxt = relay_r + 1'b1;
          end
        end else if (mode_r[relay_r] != MODE_TIMETABLE) begin
          level_nxt = wave_level(mode_r[relay_r], hour_r, minute_r, second_r);
          state_nxt = S_EMIT;
        end else begin
          if (int'(count_r[relay_r]) > SLOTS_PER_RELAY) begin
            limit_nxt = CW'(SLOTS_PER_RELAY);
          end else begin
            limit_nxt = CW'(count_r[relay_r]);
          end
          slot_nxt  = '0;
          pend_nxt  = 1'b0;
          level_nxt = 1'b0;
          state_nxt = (count_r[relay_r] == 4'd0) ? S_EMIT : S_WALK;
        end
      end
      S_WALK: begin
        // Read one slot a cycle and check the slot read the cycle before.
        rd_en    = (slot_r < limit_r);
        pend_nxt = rd_en;
        if (rd_en) begin
          slot_nxt = slot_r + 1'b1;
        end
        if (pend_r && slot_hit(mem_q, want_r, now_r)) begin
          level_nxt = 1'b1;
        end
        if (!rd_en && pend_r) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!r_full) begin
          r_push = 1'b1;
          if (relay_r == LAST_RELAY) begin
            state_nxt = S_IDLE;
          end else begin
            relay_nxt = relay_r + 1'b1;
            state_nxt = S_RELAY;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      relay_r <= '0;
      slot_r  <= '0;
      limit_r <= '0;
      pend_r  <= 1'b0;
      level_r <= 1'b0;
      for (int k = 0; k < RELAY_COUNT; k++) begin
        count_r[k]  <= '0;
        mode_r[k]   <= MODE_TIMETABLE;
        manual_r[k] <= 1'b0;
      end
    end else begin
      state_r  <= state_nxt;
      relay_r  <= relay_nxt;
      slot_r   <= slot_nxt;
      limit_r  <= limit_nxt;
      pend_r   <= pend_nxt;
      level_r  <= level_nxt;
      count_r  <= count_nxt;
      mode_r   <= mode_nxt;
      manual_r <= manual_nxt;
    end
  end

  // Tick time registers.
  always_ff @(posedge clk) begin
    want_r   <= want_nxt;
    now_r    <= now_nxt;
    hour_r   <= hour_nxt;
    minute_r <= minute_nxt;
    second_r <= second_nxt;
  end

  // Slot table memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/weekly_relay_schedule_timer.sv
// ---------------------------------------------------------------------------
// Weekly relay schedule timer
// Time switch for a bank of relays driven by timetables or wave patterns.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on in_data with push; full holds them off. A load request
//   stores one timetable slot, a relay request sets a relay's slot count, mode
//   and manual flag, and a tick request produces one result per automatic
//   relay, in relay order, with last set on the final one of the tick.
//   Results leave on out_data while empty is low and are taken with pop.
// Flow:
//   A request passes the front stage register and the command queue. Loads and
//   relay settings are then done in the back end's idle state. A tick visits
//   every relay in order: manual relays are skipped, wave relays and timetable
//   relays with a zero count resolve at once, and other timetable relays walk
//   their used slots (capped at SLOTS_PER_RELAY), since the slot table memory
//   gives one slot a cycle.
// Reset and stalls:
//   Reset clears relay settings to timetable mode, zero slots, automatic.
//   Slots are undefined until loaded. When pop stays low the result queue
//   fills, the back end waits, and then the front queue fills and full rises.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module weekly_relay_schedule_timer #(
  parameter int RELAY_COUNT     = wrsched_pkg::DEF_RELAY_COUNT,
  parameter int SLOTS_PER_RELAY = wrsched_pkg::DEF_SLOTS_PER_RELAY
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  wrsched_pkg::in_item_t  in_data,
  output logic                   empty,
  input  logic                   pop,
  output wrsched_pkg::out_item_t out_data
);
  import wrsched_pkg::*;

  logic      cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t      cmd_in, cmd_out;
  logic      res_push, res_full;
  out_item_t res_in;

  // Front end: accept and classify requests.
  wrsched_front #(
    .RELAY_COUNT    (RELAY_COUNT),
    .SLOTS_PER_RELAY(SLOTS_PER_RELAY)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .in_data(in_data),
    .q_push (cmd_push),
    .q_full (cmd_full),
    .q_data (cmd_in)
  );

  // Command queue between front and back.
  wrsched_fifo #(
    .data_t(cmd_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (cmd_push),
    .wr_data(cmd_in),
    .full   (cmd_full),
    .pop    (cmd_pop),
    .rd_data(cmd_out),
    .empty  (cmd_empty)
  );

  // Back end: execute commands and walk timetables.
  wrsched_back #(
    .RELAY_COUNT    (RELAY_COUNT),
    .SLOTS_PER_RELAY(SLOTS_PER_RELAY)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_empty(cmd_empty),
    .q_pop  (cmd_pop),
    .q_data (cmd_out),
    .r_full (res_full),
    .r_push (res_push),
    .r_data (res_in)
  );

  // Result queue towards the receiver.
  wrsched_fifo #(
    .data_t(out_item_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (res_push),
    .wr_data(res_in),
    .full   (res_full),
    .pop    (pop),
    .rd_data(out_data),
    .empty  (empty)
  );

  // Neither queue is ever written while full.
  `WRS_ASSERT_NEVER(a_cmd_no_overflow, cmd_push && cmd_full)
  `WRS_ASSERT_NEVER(a_res_no_overflow, res_push && res_full)
  // Every result names a relay that exists.
  `WRS_ASSERT_IMPLIES(a_relay_in_range, !empty, int'(out_data.out_relay) < RELAY_COUNT)
  // A result written to a full-free queue is visible on the next cycle.
  `WRS_ASSERT_NEXT(a_result_visible, res_push, !empty)

endmodule

FILE: test/tb.sv
// ---------------------------------------------------------------------------
// Weekly relay schedule timer testbench
// Queues slot loads, relay settings and time ticks into the timer with random
// gaps. A posedge monitor mirrors the relay bank and compares every relay
// level that comes out against the level it predicted for that tick.
// ---------------------------------------------------------------------------
module tb;
  import wrsched_pkg::*;

  localparam int RELAYS      = DEF_RELAY_COUNT;
  localparam int SLOTS       = DEF_SLOTS_PER_RELAY;
  localparam int RANDOM_REQS = 260;
  localparam int TAIL_CYCLES = 200;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PRINT_LIMIT = 40;
  localparam int SIDE_IN     = 0;
  localparam int SIDE_OUT    = 1;
  localparam int DAY_END     = 86399;

  // Mode codes past the seven wave patterns.
  localparam logic [3:0] MODE_UNKNOWN = 4'd8;
  localparam logic [3:0] MODE_TOP     = 4'd15;

  // Weekdays as a tick carries them, and day selectors as a slot stores them.
  localparam int WD_SUN  = 0;
  localparam int WD_MON  = 1;
  localparam int WD_WED  = 3;
  localparam int WD_SAT  = 6;
  localparam int WD_BAD  = 7;
  localparam int SEL_MON = 2;
  localparam int SEL_SAT = 7;

  logic      clk;
  logic      rst_n;
  logic      push;
  logic      full;
  in_item_t  in_data;
  logic      empty;
  logic      pop;
  out_item_t out_data;

  weekly_relay_schedule_timer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // Requests waiting for the driver and relay levels waiting for the monitor.
  in_item_t  pending_requests[$];
  out_item_t due_levels[$];

  // Mirror of the relay bank.
  slot_entry_t slot_mem[RELAYS][SLOTS];
  logic [3:0]  count_mem[RELAYS];
  logic [3:0]  mode_mem[RELAYS];
  logic        manual_mem[RELAYS];

  // What the generator has loaded so far, so no tick reads an empty slot.
  bit          gen_loaded[RELAYS][SLOTS];
  int unsigned gen_on[RELAYS][SLOTS];
  int unsigned gen_off[RELAYS][SLOTS];

  int sent_count;
  int accept_count;
  int result_count;
  int result_seen;
  int fail_count;
  int cycle_count;
  int in_wait;
  int out_wait;
  int stretch_left[2];
  bit stretch_quiet[2];

  // Wait before the next request or pop, in stretches that are busy or calm.
  function automatic int draw_wait(int side);
    if (stretch_left[side] == 0) begin
      stretch_left[side] = $urandom_range(8, 40);
      stretch_quiet[side] = ($urandom_range(0, 2) == 0);
    end
    stretch_left[side]--;
    return stretch_quiet[side] ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic bit wave_on(logic [3:0] mode, int unsigned hh, int unsigned mm,
                                 int unsigned ss);
    case (mode)
      MODE_ALWAYS:    return 1'b1;
      MODE_HALF_HOUR: return (mm % 30) < 15;
      MODE_HOUR:      return (mm % 60) < 30;
      MODE_EVEN_HOUR: return (hh % 2) == 0;
      MODE_SIX_HOUR:  return (hh % 12) < 6;
      MODE_HALF_DAY:  return (hh % 24) < 12;
      MODE_TEN_SEC:   return (ss % 20) < 10;
      default:        return 1'b0;
    endcase
  endfunction

  // Any valid slot of the relay that covers this day and second turns it on.
  function automatic bit timetable_on(int r, int unsigned wday, int unsigned now_s);
    int          n;
    bit          on;
    slot_entry_t e;
    n = (count_mem[r] > SLOTS) ? SLOTS : int'(count_mem[r]);
    on = 1'b0;
    for (int j = 0; j < n; j++) begin
      e = slot_mem[r][j];
      if (e.day != DAY_EVERY && int'(e.day) != wday + 1) continue;
      if (e.on_seconds < e.off_seconds) begin
        if (now_s >= e.on_seconds && now_s < e.off_seconds) on = 1'b1;
      end else if (e.on_seconds > e.off_seconds) begin
        if (now_s >= e.on_seconds || now_s < e.off_seconds) on = 1'b1;
      end else begin
        on = 1'b1;
      end
    end
    return on;
  endfunction

  // Update the mirror for one accepted request and queue the levels it yields.
  function automatic void apply_request(in_item_t req);
    int          last_auto;
    int unsigned now_s;
    out_item_t   lvl;
    case (req.action)
      ACT_LOAD: begin
        slot_mem[req.relay_index][req.slot_index].day = req.day;
        slot_mem[req.relay_index][req.slot_index].on_seconds = req.on_seconds;
        slot_mem[req.relay_index][req.slot_index].off_seconds = req.off_seconds;
      end
      ACT_RELAY: begin
        count_mem[req.relay_index] = req.event_count;
        mode_mem[req.relay_index] = req.relay_mode;
        manual_mem[req.relay_index] = req.manual;
      end
      ACT_TICK: begin
        now_s = int'(req.hour) * 3600 + int'(req.minute) * 60 + int'(req.second);
        last_auto = -1;
        for (int i = 0; i < RELAYS; i++) begin
          if (!manual_mem[i]) last_auto = i;
        end
        for (int i = 0; i < RELAYS; i++) begin
          if (!manual_mem[i]) begin
            lvl.out_relay = i[2:0];
            if (mode_mem[i] == MODE_TIMETABLE) begin
              lvl.relay_on = timetable_on(i, req.day, now_s);
            end else begin
              lvl.relay_on = wave_on(mode_mem[i], req.hour, req.minute, req.second);
            end
            lvl.last = (i == last_auto);
            due_levels.push_back(lvl);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // A request with every field random; callers then set the fields that matter.
  function automatic in_item_t noise_request();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic void queue_load(int r, int s, int sel, int unsigned on_s,
                                     int unsigned off_s);
    in_item_t req;
    req = noise_request();
    req.action = ACT_LOAD;
    req.relay_index = r[2:0];
    req.slot_index = s[2:0];
    req.day = sel[2:0];
    req.on_seconds = 17'(on_s);
    req.off_seconds = 17'(off_s);
    pending_requests.push_back(req);
    gen_loaded[r][s] = 1'b1;
    gen_on[r][s] = on_s & 32'h1FFFF;
    gen_off[r][s] = off_s & 32'h1FFFF;
  endfunction

  function automatic int unsigned random_second();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return $urandom_range(DAY_END + 1, 131071);
    return $urandom_range(0, DAY_END);
  endfunction

  function automatic void queue_random_load(int r, int s);
    int unsigned on_s;
    int unsigned off_s;
    on_s = random_second();
    off_s = ($urandom_range(0, 7) == 0) ? on_s : random_second();
    queue_load(r, s, $urandom_range(0, 7), on_s, off_s);
  endfunction

  // A timetable relay under automatic control first gets every slot it reads.
  function automatic void queue_relay(int r, int cnt, logic [3:0] mode, bit man);
    in_item_t req;
    int       used;
    if (mode == MODE_TIMETABLE && !man) begin
      used = (cnt > SLOTS) ? SLOTS : cnt;
      for (int s = 0; s < used; s++) begin
        if (!gen_loaded[r][s]) queue_random_load(r, s);
      end
    end
    req = noise_request();
    req.action = ACT_RELAY;
    req.relay_index = r[2:0];
    req.event_count = cnt[3:0];
    req.relay_mode = mode;
    req.manual = man;
    pending_requests.push_back(req);
  endfunction

  function automatic void queue_tick(int wday, int hh, int mm, int ss);
    in_item_t req;
    req = noise_request();
    req.action = ACT_TICK;
    req.day = wday[2:0];
    req.hour = hh[4:0];
    req.minute = mm[5:0];
    req.second = ss[5:0];
    pending_requests.push_back(req);
  endfunction

  function automatic void queue_unused();
    in_item_t req;
    req = noise_request();
    req.action = ACT_UNUSED;
    pending_requests.push_back(req);
  endfunction

  function automatic logic [3:0] random_mode();
    if ($urandom_range(0, 1) == 0) return MODE_TIMETABLE;
    return 4'($urandom_range(1, 15));
  endfunction

  // Ticks mostly land in a normal day, often right on a slot edge.
  function automatic void queue_random_tick();
    int          pick;
    int          r;
    int          s;
    int unsigned t;
    pick = $urandom_range(0, 99);
    r = $urandom_range(0, RELAYS - 1);
    s = $urandom_range(0, SLOTS - 1);
    if (pick < 35 && gen_loaded[r][s]) begin
      t = ($urandom_range(0, 1) == 0) ? gen_on[r][s] : gen_off[r][s];
      if ($urandom_range(0, 2) == 0 && t > 0) t = t - 1;
      if (t > DAY_END) t = $urandom_range(0, DAY_END);
      queue_tick($urandom_range(0, 7), t / 3600, (t % 3600) / 60, t % 60);
    end else if (pick < 85) begin
      queue_tick($urandom_range(0, 7), $urandom_range(0, 23), $urandom_range(0, 59),
                 $urandom_range(0, 59));
    end else begin
      queue_tick($urandom_range(0, 7), $urandom_range(0, 31), $urandom_range(0, 63),
                 $urandom_range(0, 63));
    end
  endfunction

  // Driver: present the next request once the current one is taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (sent_count == accept_count) begin
        if (in_wait > 0) begin
          in_wait--;
          push <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          in_data <= pending_requests.pop_front();
          push <= 1'b1;
          sent_count++;
          in_wait = draw_wait(SIDE_IN);
        end else begin
          push <= 1'b0;
        end
      end
      if (result_count != result_seen) begin
        result_seen = result_count;
        out_wait = draw_wait(SIDE_OUT);
      end
      if (out_wait > 0) begin
        out_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Monitor: check each relay level taken, then mirror each request taken.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (pop && !empty) begin
        result_count++;
        if (due_levels.size() == 0) begin
          fail_count++;
          if (fail_count <= PRINT_LIMIT) begin
            $display("%0t: unexpected level relay=%0d on=%0d last=%0d", $time,
                     out_data.out_relay, out_data.relay_on, out_data.last);
          end
        end else begin
          want = due_levels.pop_front();
          if (out_data.out_relay !== want.out_relay || out_data.relay_on !== want.relay_on ||
              out_data.last !== want.last) begin
            fail_count++;
            if (fail_count <= PRINT_LIMIT) begin
              $display("%0t: expected relay=%0d on=%0d last=%0d, got relay=%0d on=%0d last=%0d",
                       $time, want.out_relay, want.relay_on, want.last,
                       out_data.out_relay, out_data.relay_on, out_data.last);
            end
          end
        end
      end
      if (push && !full) begin
        accept_count++;
        apply_request(in_data);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    bit manual_pass;
    int pick;
    clk = 1'b0;
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_data = '0;
    sent_count = 0;
    accept_count = 0;
    result_count = 0;
    result_seen = 0;
    fail_count = 0;
    cycle_count = 0;
    in_wait = 0;
    out_wait = 0;
    stretch_left = '{0, 0};
    stretch_quiet = '{1'b0, 1'b0};
    for (int r = 0; r < RELAYS; r++) begin
      count_mem[r] = '0;
      mode_mem[r] = MODE_TIMETABLE;
      manual_mem[r] = 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
        slot_mem[r][s] = '0;
        gen_loaded[r][s] = 1'b0;
      end
    end

    // Fresh bank: every relay is a timetable with no slots, so all are off.
    queue_tick(WD_SUN, 0, 0, 0);
    // A plain window, a window past midnight, an all-day slot, extreme times.
    queue_load(0, 0, DAY_EVERY, 3600, 7200);
    queue_load(0, 1, SEL_MON, 82800, 3600);
    queue_load(1, 0, DAY_EVERY, 1000, 1000);
    queue_load(2, 0, SEL_SAT, 0, 131071);
    queue_relay(0, 2, MODE_TIMETABLE, 1'b0);
    queue_relay(1, 1, MODE_TIMETABLE, 1'b0);
    queue_relay(2, 1, MODE_TIMETABLE, 1'b0);
    queue_relay(3, 0, MODE_ALWAYS, 1'b0);
    queue_relay(4, 3, MODE_HALF_HOUR, 1'b0);
    queue_relay(5, 0, MODE_HOUR, 1'b0);
    queue_relay(6, 0, MODE_EVEN_HOUR, 1'b0);
    queue_relay(7, 0, MODE_SIX_HOUR, 1'b0);
    queue_tick(WD_MON, 23, 59, 59);
    queue_tick(WD_SAT, 1, 0, 0);
    // Weekday seven only matches every-day slots; the window end is exclusive.
    queue_tick(WD_BAD, 2, 0, 0);
    // Remaining waves, unknown modes, and a manual relay with too many slots.
    queue_relay(3, 0, MODE_HALF_DAY, 1'b0);
    queue_relay(4, 0, MODE_TEN_SEC, 1'b0);
    queue_relay(5, 0, MODE_UNKNOWN, 1'b0);
    queue_relay(6, 15, MODE_TOP, 1'b0);
    queue_relay(7, 15, MODE_TIMETABLE, 1'b1);
    // Time fields beyond a normal day are used as given.
    queue_tick(WD_WED, 31, 63, 63);
    queue_tick(WD_SUN, 12, 15, 9);
    queue_unused();

    // Random traffic up to the request budget, with one pass where every relay
    // goes manual. Slot loads added ahead of timetable settings count as well.
    manual_pass = 1'b0;
    while (pending_requests.size() < RANDOM_REQS) begin
      if (!manual_pass && pending_requests.size() >= RANDOM_REQS / 2) begin
        for (int r = 0; r < RELAYS; r++) queue_relay(r, $urandom_range(0, 15), random_mode(), 1'b1);
        queue_tick($urandom_range(0, 7), $urandom_range(0, 23), $urandom_range(0, 59),
                   $urandom_range(0, 59));
        for (int r = 0; r < RELAYS; r++) queue_relay(r, $urandom_range(0, 15), random_mode(), 1'b0);
        manual_pass = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        queue_random_load($urandom_range(0, RELAYS - 1), $urandom_range(0, SLOTS - 1));
      end else if (pick < 42) begin
        queue_relay($urandom_range(0, RELAYS - 1), $urandom_range(0, 15), random_mode(),
                    $urandom_range(0, 4) == 0);
      end else if (pick < 95) begin
        queue_random_tick();
      end else begin
        queue_unused();
      end
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || sent_count != accept_count ||
           due_levels.size() != 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && due_levels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/wrsched_pkg.sv
hdl/wrsched_fifo.sv
hdl/wrsched_front.sv
hdl/wrsched_back.sv
hdl/weekly_relay_schedule_timer.sv
test/tb.sv
